// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions with a common clock and disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define TSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define TSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Transaction types, operation codes and the control store of the sorted queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tsq_pkg;

   // Operation codes carried in the request.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] stamp;
      logic [15:0] msg_source;
      logic [7:0]  msg_sequence;
      logic [7:0]  msg_length;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  fill_count;
      logic        head_valid;
      logic [31:0] head_stamp;
      logic [15:0] head_source;
      logic [7:0]  head_sequence;
      logic [7:0]  head_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] msg_source;
      logic [7:0]  msg_sequence;
      logic [7:0]  msg_length;
   } entry_type;

   // Sequencer step addresses.
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_ONE       = 4'd1;
   localparam step_type STEP_INS0      = 4'd0;
   localparam step_type STEP_INS1      = 4'd1;
   localparam step_type STEP_INS2      = 4'd2;
   localparam step_type STEP_INS3      = 4'd3;
   localparam step_type STEP_INS_PLACE = 4'd4;
   localparam step_type STEP_KEY0      = 4'd5;
   localparam step_type STEP_KEY1      = 4'd6;
   localparam step_type STEP_KEY2      = 4'd7;
   localparam step_type STEP_KEY3      = 4'd8;
   localparam step_type STEP_POP0      = 4'd9;
   localparam step_type STEP_DEL0      = 4'd10;
   localparam step_type STEP_DEL1      = 4'd11;
   localparam step_type STEP_DEL_END   = 4'd12;
   localparam step_type STEP_FIN       = 4'd13;
   localparam step_type STEP_OUT       = 4'd14;

   typedef enum logic [2:0] {
      RD_ZERO,
      RD_PTR_M1,
      RD_PTR_M2,
      RD_PTR_P1,
      RD_PTR_P2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT,
      WR_NEW
   } wr_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_COUNT,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [3:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_FULL,
      COND_EMPTY,
      COND_PTR_ZERO,
      COND_PTR_NOT_ONE,
      COND_NOT_GREATER,
      COND_MATCH,
      COND_LAST,
      COND_NOT_LAST,
      COND_NOT_LAST2
   } cond_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      ptr_op_type ptr_op;
      cnt_op_type cnt_op;
      logic       set_ok;
      logic       finish;
      cond_type   cond;
      step_type   target;
   } ucode_type;

   // First step of the routine for each operation code.
   function automatic step_type entry_step(input logic [1:0] op);
      step_type s;
      case (op)
         OP_INSERT: s = STEP_INS0;
         OP_POP:    s = STEP_POP0;
         OP_REMOVE: s = STEP_KEY0;
         default:   s = STEP_FIN;
      endcase
      return s;
   endfunction

   // Control store: one control word per step.
   function automatic ucode_type ucode_word(input step_type upc);
      ucode_type w;
      w.rd_sel = RD_ZERO;
      w.wr_sel = WR_NONE;
      w.ptr_op = PTR_HOLD;
      w.cnt_op = CNT_HOLD;
      w.set_ok = 1'b0;
      w.finish = 1'b0;
      w.cond   = COND_NEXT;
      w.target = STEP_FIN;
      unique case (upc)
         STEP_INS0: begin
            w.ptr_op = PTR_COUNT;
            w.cond   = COND_FULL;
         end
         STEP_INS1: begin
            w.rd_sel = RD_PTR_M1;
            w.cond   = COND_PTR_ZERO;
            w.target = STEP_INS_PLACE;
         end
         STEP_INS2: begin
            w.rd_sel = RD_PTR_M1;
            w.cond   = COND_NOT_GREATER;
            w.target = STEP_INS_PLACE;
         end
         STEP_INS3: begin
            w.wr_sel = WR_SHIFT;
            w.ptr_op = PTR_DEC;
            w.rd_sel = RD_PTR_M2;
            w.cond   = COND_PTR_NOT_ONE;
            w.target = STEP_INS2;
         end
         STEP_INS_PLACE: begin
            w.wr_sel = WR_NEW;
            w.cnt_op = CNT_INC;
            w.set_ok = 1'b1;
            w.cond   = COND_ALWAYS;
         end
         STEP_KEY0: begin
            w.ptr_op = PTR_ZERO;
            w.cond   = COND_EMPTY;
         end
         STEP_KEY1: begin
            w.cond   = COND_MATCH;
            w.target = STEP_DEL0;
         end
         STEP_KEY2: begin
            w.ptr_op = PTR_INC;
            w.rd_sel = RD_PTR_P1;
            w.cond   = COND_NOT_LAST;
            w.target = STEP_KEY1;
         end
         STEP_KEY3: begin
            w.cond   = COND_ALWAYS;
         end
         STEP_POP0: begin
            w.ptr_op = PTR_ZERO;
            w.cond   = COND_EMPTY;
         end
         STEP_DEL0: begin
            w.rd_sel = RD_PTR_P1;
            w.cond   = COND_LAST;
            w.target = STEP_DEL_END;
         end
         STEP_DEL1: begin
            w.wr_sel = WR_SHIFT;
            w.ptr_op = PTR_INC;
            w.rd_sel = RD_PTR_P2;
            w.cond   = COND_NOT_LAST2;
            w.target = STEP_DEL1;
         end
         STEP_DEL_END: begin
            w.cnt_op = CNT_DEC;
            w.set_ok = 1'b1;
         end
         STEP_FIN: begin
            w.rd_sel = RD_ZERO;
         end
         STEP_OUT: begin
            w.rd_sel = RD_ZERO;
            w.finish = 1'b1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: sv/timestamp_sorted_queue.sv
// ----------------------------------------------------------------------------
// timestamp_sorted_queue: bounded queue kept in ascending timestamp order.
// The sequencer walks the slot memory with one read and at most one write per step.
// One transaction at a time: the next is taken the cycle after a result is
// registered, even while that result waits.
// Reset clears the entry count, the sequencer and the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_sorted_queue
   import tsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Counts run from zero to QUEUE_DEPTH; slot addresses need one bit less
   // whenever the depth is a power of two above one.
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [CW:0]   ONE_X   = (CW + 1)'(1);
   localparam logic [CW:0]   TWO_X   = (CW + 1)'(2);

   // Slot storage. Data read from slots outside the live entries is never used,
   // so the memory needs no clearing after reset.
   entry_type slot_mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // Sequencer and datapath registers.
   logic            busy_ff;
   step_type        upc_ff;
   logic [CW-1:0]   ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            ok_ff;
   req_type         item_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   ucode_type       uw;
   logic            cond_true;
   logic            out_free;
   logic            step_go;
   logic            wr_en;
   logic [AW-1:0]   rd_addr;
   entry_type       wr_data;
   logic [CW-1:0]   ptr_m1;
   logic [CW-1:0]   ptr_m2;
   logic [CW:0]     ptr_p1;
   logic [CW:0]     ptr_p2;
   logic [CW:0]     cnt_ext;
   rsp_type         rsp_in;

   // The control word for the current step comes straight from the store.
   assign uw = ucode_word(upc_ff);

   assign ptr_m1  = ptr_ff - ONE_C;
   assign ptr_m2  = ptr_m1 - ONE_C;
   assign ptr_p1  = {1'b0, ptr_ff} + ONE_X;
   assign ptr_p2  = {1'b0, ptr_ff} + TWO_X;
   assign cnt_ext = {1'b0, count_ff};

   // The output register is free when empty or when its transaction leaves
   // at this edge. The final step waits for it; every other step advances.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step_go  = busy_ff && !(uw.finish && !out_free);
   assign wr_en    = step_go && (uw.wr_sel != WR_NONE);

   // Read address for the single read port. Addresses computed past the
   // live entries only occur on steps whose read data is then discarded.
   always_comb begin
      unique case (uw.rd_sel)
         RD_ZERO:   rd_addr = '0;
         RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
         RD_PTR_M2: rd_addr = ptr_m2[AW-1:0];
         RD_PTR_P1: rd_addr = ptr_p1[AW-1:0];
         RD_PTR_P2: rd_addr = ptr_p2[AW-1:0];
         default:   rd_addr = '0;
      endcase
   end

   // A shift writes back the slot read on the step before; a placement
   // writes the new entry from the captured request.
   always_comb begin
      if (uw.wr_sel == WR_NEW) begin
         wr_data.stamp        = item_ff.stamp;
         wr_data.msg_source   = item_ff.msg_source;
         wr_data.msg_sequence = item_ff.msg_sequence;
         wr_data.msg_length   = item_ff.msg_length;
      end else begin
         wr_data = rd_data_ff;
      end
   end

   // Jump conditions. They look at the pointer and count as they stand at
   // the start of the step and at the slot read by the step before.
   always_comb begin
      unique case (uw.cond)
         COND_NEXT:        cond_true = 1'b0;
         COND_ALWAYS:      cond_true = 1'b1;
         COND_FULL:        cond_true = (count_ff == DEPTH_C);
         COND_EMPTY:       cond_true = (count_ff == '0);
         COND_PTR_ZERO:    cond_true = (ptr_ff == '0);
         COND_PTR_NOT_ONE: cond_true = (ptr_ff != ONE_C);
         COND_NOT_GREATER: cond_true = (rd_data_ff.stamp <= item_ff.stamp);
         COND_MATCH:       cond_true = (rd_data_ff.msg_source == item_ff.msg_source) &&
                                       (rd_data_ff.msg_sequence == item_ff.msg_sequence);
         COND_LAST:        cond_true = (ptr_p1 >= cnt_ext);
         COND_NOT_LAST:    cond_true = (ptr_p1 < cnt_ext);
         COND_NOT_LAST2:   cond_true = (ptr_p2 < cnt_ext);
         default:          cond_true = 1'b0;
      endcase
   end

   // Result built on the final step, when the read data holds slot zero.
   always_comb begin
      rsp_in.accepted   = ok_ff;
      rsp_in.fill_count = 4'(count_ff);
      rsp_in.head_valid = (count_ff != '0);
      if (count_ff != '0) begin
         rsp_in.head_stamp    = rd_data_ff.stamp;
         rsp_in.head_source   = rd_data_ff.msg_source;
         rsp_in.head_sequence = rd_data_ff.msg_sequence;
         rsp_in.head_length   = rd_data_ff.msg_length;
      end else begin
         rsp_in.head_stamp    = '0;
         rsp_in.head_source   = '0;
         rsp_in.head_sequence = '0;
         rsp_in.head_length   = '0;
      end
   end

   // Slot memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[ptr_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   // Sequencer, datapath registers and the response register. An accepted
   // transaction starts at the first step of its routine; each step then
   // either falls through or takes its jump.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= STEP_FIN;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A result leaving at this edge frees the register unless the final
         // step refills it at the same edge.
         if (rsp_valid_ff && !rsp_stall && !(step_go && uw.finish)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (!busy_ff && req_valid) begin
            busy_ff <= 1'b1;
            upc_ff  <= entry_step(req_data.op);
            item_ff <= req_data;
            ok_ff   <= 1'b0;
         end else if (step_go) begin
            upc_ff <= cond_true ? uw.target : upc_ff + STEP_ONE;
            case (uw.ptr_op)
               PTR_COUNT: ptr_ff <= count_ff;
               PTR_ZERO:  ptr_ff <= '0;
               PTR_INC:   ptr_ff <= ptr_ff + ONE_C;
               PTR_DEC:   ptr_ff <= ptr_m1;
               default:   ptr_ff <= ptr_ff;
            endcase
            case (uw.cnt_op)
               CNT_INC: count_ff <= count_ff + ONE_C;
               CNT_DEC: count_ff <= count_ff - ONE_C;
               default: count_ff <= count_ff;
            endcase
            if (uw.set_ok) begin
               ok_ff <= 1'b1;
            end
            if (uw.finish) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= rsp_in;
               busy_ff      <= 1'b0;
            end
         end
      end
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/tsq_checker.sv
// ----------------------------------------------------------------------------
// tsq_checker
// Port-level checks on the sorted queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tsq_checker
   import tsq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled response transaction stays valid and unchanged.
   `TSQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

   // An empty queue reports a zero head entry.
   `TSQ_ASSERT_NOW(a_empty_head_zero, clock, reset, rsp_valid && !rsp_data.head_valid, (rsp_data.head_stamp == '0) && (rsp_data.head_source == '0) && (rsp_data.head_sequence == '0) && (rsp_data.head_length == '0), "empty queue reported a head entry")

   // Reset leaves no response pending.
   `TSQ_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   // Only one request transaction is worked on at a time.
   `TSQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

endmodule

bind timestamp_sorted_queue tsq_checker u_tsq_checker (.*);

`default_nettype wire
